@@ rtl/core/sequential_list_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sequential list engine checker
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine package
// Shared constants: default capacity and request action codes.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY_DEF = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_LOCATE = 2'd3
	} action_t;

endpackage

@@ rtl/core/sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of 32-bit values in one synchronous memory with a length
// count: insert, delete, update and locate by value, one request at a time.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   action, position, value
//  m_*      out  m_tvalid/m_tready   ok, removed_value, found_position, list_length
//
//  Update and a rejected position go straight to the result; insert moves
//  the entries from the end down to position up by one, delete moves the
//  entries after position down by one, and locate compares from the head on:
//  the single memory moves or compares one entry a cycle.
//  After reset a fill pass loads entry k with k+1;
//  s_tready stays low during it. A stalled result holds in the output
//  register while the next request is taken.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // action[1:0], position[7:2], value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // ok[0], removed_value[32:1],
	                               // found_position[38:33], list_length[44:39], zero fill
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 6) ? CW : 6) + 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_INS, ST_PUT, ST_DEL, ST_LOC, ST_FIN
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cur_q;
	logic [CW-1:0] count_q;
	logic [5:0]    pos_q;
	logic [31:0]   val_q;
	logic          first_q;
	logic          res_ok_q;
	logic [31:0]   res_rem_q;
	logic [5:0]    res_found_q;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_data_s1;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_wdata;

	logic [1:0]    in_action;
	logic [5:0]    in_position;
	logic [31:0]   in_value;
	logic [PW-1:0] in_pos_w;
	logic [PW-1:0] count_w;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cur_w;
	logic [PW-1:0] found_w;
	logic          ins_ok;
	logic          pos_ok;

	// Unpack the request and widen counts for compares
	assign in_action   = s_tdata[1:0];
	assign in_position = s_tdata[7:2];
	assign in_value    = s_tdata[39:8];
	assign in_pos_w    = PW'(in_position);
	assign count_w     = PW'(count_q);
	assign pos_w       = PW'(pos_q);
	assign cur_w       = PW'(cur_q);
	assign found_w     = cur_w + PW'(1);

	assign ins_ok = (in_pos_w != '0) && (in_pos_w <= count_w + PW'(1))
		&& (count_w < PW'(CAPACITY));
	assign pos_ok = (in_pos_w != '0) && (in_pos_w <= count_w);

	assign s_tready = (state_q == ST_IDLE);

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = val_q;
		mem_raddr = cur_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = 32'(found_w);
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (sle_pkg::action_t'(in_action))
						sle_pkg::ACT_INSERT: mem_raddr = AW'(count_w - PW'(1));
						sle_pkg::ACT_DELETE: mem_raddr = AW'(in_pos_w - PW'(1));
						sle_pkg::ACT_UPDATE: begin
							mem_we    = pos_ok;
							mem_waddr = AW'(in_pos_w - PW'(1));
							mem_wdata = in_value;
						end
						sle_pkg::ACT_LOCATE: mem_raddr = '0;
						default: mem_raddr = cur_q;
					endcase
				end
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(found_w);
				mem_wdata = rd_data_s1;
				mem_raddr = AW'(cur_w - PW'(1));
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_w - PW'(1));
			end
			ST_DEL: begin
				mem_we    = !first_q;
				mem_waddr = AW'(cur_w - PW'(1));
				mem_wdata = rd_data_s1;
				mem_raddr = AW'(found_w);
			end
			ST_LOC: mem_raddr = AW'(found_w);
			ST_FIN: mem_raddr = cur_q;
			default: mem_raddr = cur_q;
		endcase
	end

	// List storage, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_q       <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			val_q       <= '0;
			first_q     <= 1'b0;
			res_ok_q    <= 1'b0;
			res_rem_q   <= '0;
			res_found_q <= '0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
		end else begin
			// load a finished result, or drop the result once taken
			if (state_q == ST_FIN && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cur_w == PW'(CAPACITY - 1)) begin
						count_q <= CW'(CAPACITY);
						cur_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						pos_q       <= in_position;
						val_q       <= in_value;
						res_ok_q    <= 1'b0;
						res_rem_q   <= '0;
						res_found_q <= '0;
						state_q     <= ST_FIN;
						unique case (sle_pkg::action_t'(in_action))
							sle_pkg::ACT_INSERT: begin
								if (ins_ok) begin
									if (in_pos_w <= count_w) begin
										cur_q   <= AW'(count_w - PW'(1));
										state_q <= ST_INS;
									end else begin
										state_q <= ST_PUT;
									end
								end
							end
							sle_pkg::ACT_DELETE: begin
								if (pos_ok) begin
									cur_q   <= AW'(in_pos_w - PW'(1));
									first_q <= 1'b1;
									state_q <= ST_DEL;
								end
							end
							sle_pkg::ACT_UPDATE: res_ok_q <= pos_ok;
							sle_pkg::ACT_LOCATE: begin
								if (count_q != '0) begin
									cur_q   <= '0;
									state_q <= ST_LOC;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_INS: begin
					// move entries up, the last one moved is the one from the insert slot
					if (cur_w == pos_w - PW'(1)) begin
						state_q <= ST_PUT;
					end else begin
						cur_q <= cur_q - AW'(1);
					end
				end
				ST_PUT: begin
					count_q  <= count_q + CW'(1);
					res_ok_q <= 1'b1;
					state_q  <= ST_FIN;
				end
				ST_DEL: begin
					first_q <= 1'b0;
					if (first_q) begin
						res_rem_q <= rd_data_s1;
					end
					if (cur_w == count_w - PW'(1)) begin
						count_q  <= count_q - CW'(1);
						res_ok_q <= 1'b1;
						state_q  <= ST_FIN;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				ST_LOC: begin
					if (rd_data_s1 == val_q) begin
						res_ok_q    <= 1'b1;
						res_found_q <= found_w[5:0];
						state_q     <= ST_FIN;
					end else if (cur_w == count_w - PW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tdata <= {3'b000, count_w[5:0], res_found_q, res_rem_q, res_ok_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/sle_checker.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine port checker
// Watches the top-level ports for result consistency and request pacing.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_macros.svh"

module sle_checker #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// hold a stalled result
	`SLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// one request at a time
	`SLE_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// a failed request removes nothing
	`SLE_ASSERT_NOW(a_fail_rem, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "removed value on failure")

	// a found position implies success
	`SLE_ASSERT_NOW(a_found_ok, m_tvalid && (m_tdata[38:33] != 6'd0), m_tdata[0], "found position without ok")

	// length never exceeds capacity
	`SLE_ASSERT_NOW(a_len_cap, m_tvalid && (CAPACITY < 64), 32'(m_tdata[44:39]) <= 32'(CAPACITY), "length above capacity")

endmodule

bind sequential_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);
